### hw/rtl/ssfad_pkg.sv
// Shared types, constants and helpers for the servo status frame decoder.
package ssfad_pkg;

  localparam logic [7:0] HdrByte      = 8'hFF;
  localparam logic [7:0] LenByte      = 8'h0A;
  localparam logic [7:0] ServoIdReset = 8'h01;

  localparam logic [15:0] SignThreshold = 16'd1024;
  localparam logic [9:0]  LoadDivisor   = 10'd1023;
  localparam logic [3:0]  SpeedStep     = 4'd11;

  localparam logic [7:0]  VoltLowLimit  = 8'd120;
  localparam logic [7:0]  VoltMidLimit  = 8'd148;
  localparam logic [11:0] TorqueLow     = 12'd2300;
  localparam logic [11:0] TorqueMid     = 12'd2500;
  localparam logic [11:0] TorqueHigh    = 12'd3100;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ROTATE,
    BK_MUL,
    BK_DIV,
    BK_FIX,
    BK_OUT
  } back_state_e;

  // Stall torque in mN*m for a supply voltage code in tenths of a volt.
  function automatic logic [11:0] stall_torque(input logic [7:0] volt);
    logic [11:0] t;
    if (volt < VoltLowLimit) begin
      t = TorqueLow;
    end else if (volt < VoltMidLimit) begin
      t = TorqueMid;
    end else begin
      t = TorqueHigh;
    end
    return t;
  endfunction

endpackage

### hw/rtl/ssfad_if.sv
// Channel interfaces: received bytes, servo id writes and decoded results.
interface ssfad_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ssfad_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] servo_id;
  modport source (output valid, output servo_id, input ready);
  modport sink (input valid, input servo_id, output ready);
endinterface

interface ssfad_res_if;
  logic               valid;
  logic               ready;
  logic               frame_found;
  logic [15:0]        position;
  logic signed [20:0] speed_centi_rpm;
  logic signed [18:0] load_milli_nm;
  logic [7:0]         voltage_decivolts;
  logic [7:0]         temperature_c;
  modport source (output valid, output frame_found, output position, output speed_centi_rpm,
                  output load_milli_nm, output voltage_decivolts, output temperature_c,
                  input ready);
  modport sink (input valid, input frame_found, input position, input speed_centi_rpm,
                input load_milli_nm, input voltage_decivolts, input temperature_c,
                output ready);
endinterface

### hw/rtl/ssfad_front.sv
// Front part: byte window capture, servo id register and header search.
module ssfad_front
  import ssfad_pkg::*;
#(
  parameter int WindowBytes = 13,
  localparam int IdxW  = $clog2(WindowBytes),
  localparam int Width = WindowBytes * 8 + IdxW + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ssfad_rx_if.sink         rx,
  ssfad_cfg_if.sink        cfg,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output logic [Width-1:0] push_data_o
);

  localparam logic [IdxW-1:0] LastSlot = IdxW'(WindowBytes - 1);

  logic [7:0]      win_q [WindowBytes-1];
  logic [IdxW-1:0] wp_q, wp_d;
  logic [7:0]      servo_id_q;
  logic [7:0]      snap [WindowBytes];
  logic [WindowBytes-1:0] match;
  logic            found;
  logic [IdxW-1:0] hit;
  logic [IdxW-1:0] start;
  logic            at_last;
  logic            accept;

  assign at_last  = (wp_q == LastSlot);
  assign rx.ready = !at_last || push_ready_i;
  assign accept   = rx.valid && rx.ready;
  assign cfg.ready = 1'b1;

  // Complete window: stored slots plus the byte arriving now in the last slot.
  for (genvar k = 0; k < WindowBytes; k++) begin : g_snap
    if (k < WindowBytes - 1) begin : g_old
      assign snap[k] = win_q[k];
    end else begin : g_new
      assign snap[k] = rx.rx_byte;
    end
  end

  for (genvar p = 0; p < WindowBytes; p++) begin : g_match
    assign match[p] = (snap[p] == HdrByte) &&
                      (snap[(p + 1) % WindowBytes] == servo_id_q) &&
                      (snap[(p + 2) % WindowBytes] == LenByte);
  end

  // Search order: last-but-one, last, then 0 upward; walk backward so the first wins.
  always_comb begin
    int ord;
    found = 1'b0;
    hit   = '0;
    ord   = 0;
    for (int i = WindowBytes - 1; i >= 0; i--) begin
      if (i == 0) begin
        ord = WindowBytes - 2;
      end else if (i == 1) begin
        ord = WindowBytes - 1;
      end else begin
        ord = i - 2;
      end
      if (match[ord]) begin
        found = 1'b1;
        hit   = IdxW'(ord);
      end
    end
  end

  assign start = (hit == '0) ? LastSlot : hit - IdxW'(1);

  assign push_valid_o = accept && at_last;
  for (genvar k = 0; k < WindowBytes; k++) begin : g_pack
    assign push_data_o[8*k +: 8] = snap[k];
  end
  assign push_data_o[WindowBytes*8 +: IdxW] = start;
  assign push_data_o[Width-1]               = found;

  always_comb begin
    wp_d = wp_q;
    if (accept) begin
      wp_d = at_last ? '0 : wp_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      servo_id_q <= ServoIdReset;
    end else begin
      wp_q <= wp_d;
      if (cfg.valid) begin
        servo_id_q <= cfg.servo_id;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !at_last) begin
      win_q[wp_q] <= rx.rx_byte;
    end
  end

endmodule

### hw/rtl/ssfad_fifo.sv
// Two-entry queue between the front and back parts.
module ssfad_fifo #(
  parameter int Width = 109
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [Width-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [Width-1:0] out_data_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

### hw/rtl/ssfad_back.sv
// Back part: frame rotation, field decode and result register.
module ssfad_back
  import ssfad_pkg::*;
#(
  parameter int WindowBytes = 13,
  localparam int IdxW  = $clog2(WindowBytes),
  localparam int Width = WindowBytes * 8 + IdxW + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  output logic             q_ready_o,
  input  logic [Width-1:0] q_data_i,
  ssfad_res_if.source      res
);

  back_state_e state_q, state_d;

  logic [7:0]      rot_q [WindowBytes];
  logic [7:0]      aligned_q [WindowBytes];
  logic [IdxW-1:0] cnt_q;
  logic            found_q;
  logic [19:0]     spd_mag_q;
  logic            spd_neg_q;
  logic [27:0]     prod_q;
  logic            ld_neg_q;
  logic [18:0]     q0_q;

  logic [15:0] spd_raw, ld_raw, spd_abs, ld_abs;
  logic [11:0] torque;
  logic [28:0] approx;
  logic [28:0] back_mul;
  logic [28:0] rem;
  logic [18:0] quot;
  logic        q_take;

  assign spd_raw = {aligned_q[8], aligned_q[7]};
  assign ld_raw  = {aligned_q[10], aligned_q[9]};
  assign spd_abs = (spd_raw >= SignThreshold) ? spd_raw - SignThreshold : spd_raw;
  assign ld_abs  = (ld_raw >= SignThreshold) ? ld_raw - SignThreshold : ld_raw;
  assign torque  = stall_torque(aligned_q[11]);

  // Divide by 1023: x/1024 * (1 + 2^-10 + 2^-20) is low by at most one.
  assign approx   = {1'b0, prod_q} + {11'b0, prod_q[27:10]} + {21'b0, prod_q[27:20]};
  assign back_mul = {q0_q, 10'b0} - {10'b0, q0_q};
  assign rem      = {1'b0, prod_q} - back_mul;
  assign quot     = (rem >= {19'b0, LoadDivisor}) ? q0_q + 19'd1 : q0_q;

  assign q_take = q_valid_i && q_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          state_d = q_data_i[Width-1] ? BK_ROTATE : BK_MUL;
        end
      end
      BK_ROTATE: begin
        if (cnt_q == '0) begin
          state_d = BK_MUL;
        end
      end
      BK_MUL:  state_d = BK_DIV;
      BK_DIV:  state_d = BK_FIX;
      BK_FIX:  state_d = BK_OUT;
      BK_OUT: begin
        if (res.ready) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    q_ready_o = (state_q == BK_IDLE);
    res.valid = (state_q == BK_OUT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      for (int k = 0; k < WindowBytes; k++) begin
        aligned_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == BK_ROTATE && cnt_q == '0) begin
        for (int k = 0; k < WindowBytes; k++) begin
          aligned_q[k] <= rot_q[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        if (q_take) begin
          for (int k = 0; k < WindowBytes; k++) begin
            rot_q[k] <= q_data_i[8*k +: 8];
          end
          cnt_q   <= q_data_i[WindowBytes*8 +: IdxW];
          found_q <= q_data_i[Width-1];
        end
      end
      BK_ROTATE: begin
        // Rotate one slot toward the front per cycle until the start slot leads.
        if (cnt_q != '0) begin
          for (int k = 0; k < WindowBytes; k++) begin
            rot_q[k] <= rot_q[(k + 1) % WindowBytes];
          end
          cnt_q <= cnt_q - IdxW'(1);
        end
      end
      BK_MUL: begin
        spd_mag_q <= {4'b0, spd_abs} * {16'b0, SpeedStep};
        spd_neg_q <= (spd_raw >= SignThreshold);
        prod_q    <= {12'b0, ld_abs} * {16'b0, torque};
        ld_neg_q  <= (ld_raw >= SignThreshold);
      end
      BK_DIV: begin
        q0_q <= approx[28:10];
      end
      BK_FIX: begin
        res.frame_found       <= found_q;
        res.position          <= {aligned_q[6], aligned_q[5]};
        res.speed_centi_rpm   <= spd_neg_q ? -$signed({1'b0, spd_mag_q})
                                           : $signed({1'b0, spd_mag_q});
        res.load_milli_nm     <= ld_neg_q ? -$signed(quot) : $signed(quot);
        res.voltage_decivolts <= aligned_q[11];
        res.temperature_c     <= aligned_q[12];
      end
      default: begin
      end
    endcase
  end

endmodule

### hw/rtl/servo_status_frame_align_decode_top.sv
// Servo status frame aligner and decoder: top level.
//
// Received serial bytes enter a window of WindowBytes slots, one byte per
// rx transaction. The front part takes a byte every cycle; only the byte that
// completes a window waits, and only while the two-entry queue to the back
// part is full. On a complete window the front part finds the header triple
// 0xFF, servo id, 0x0A (positions last-but-one, last, then 0 upward) and
// queues the window with the found flag and the rotation start. The back part
// takes one queued window at a time: it rotates the window one slot per cycle
// into the aligned frame when a header was found, then multiplies, divides
// by 1023 and signs the fields in its multiply, divide and fix states and
// holds the result in its output register until the result transaction
// completes. The servo id register resets to 1 and takes effect at the next
// search; the aligned frame resets to zero, so a first window without a
// header decodes an all-zero frame.
module servo_status_frame_align_decode_top
  import ssfad_pkg::*;
#(
  parameter int WindowBytes = 13
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ssfad_rx_if.sink     rx_i,
  ssfad_cfg_if.sink    cfg_i,
  ssfad_res_if.source  res_o
);

  localparam int IdxW  = $clog2(WindowBytes);
  localparam int Width = WindowBytes * 8 + IdxW + 1;

  logic             push_valid, push_ready;
  logic [Width-1:0] push_data;
  logic             pop_valid, pop_ready;
  logic [Width-1:0] pop_data;

  // Capture bytes, hold the servo id and classify each complete window.
  ssfad_front #(
    .WindowBytes(WindowBytes)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx          (rx_i),
    .cfg         (cfg_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  // Decouple window capture from the multi-cycle decode.
  ssfad_fifo #(
    .Width(Width)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (push_valid),
    .in_ready_o (push_ready),
    .in_data_i  (push_data),
    .out_valid_o(pop_valid),
    .out_ready_i(pop_ready),
    .out_data_o (pop_data)
  );

  // Align and decode, then hold the result until it is taken.
  ssfad_back #(
    .WindowBytes(WindowBytes)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(pop_valid),
    .q_ready_o(pop_ready),
    .q_data_i (pop_data),
    .res      (res_o)
  );

  // A completed window must never be dropped at a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_valid |-> push_ready)
    else $error("window completed while queue full");

  // The back part only takes a window while no result is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (pop_valid && pop_ready) |-> !res_o.valid)
    else $error("queue popped while result pending");

  // Load never exceeds the highest stall torque: catches a divide slip.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   res_o.valid |-> (res_o.load_milli_nm <= 19'sd3100))
    else $error("load above stall torque");

  // Positive speed stays within 1023 * 11.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   res_o.valid |-> (res_o.speed_centi_rpm <= 21'sd11253))
    else $error("speed out of range");

endmodule
